### rtl/core/tcw_pkg.sv
package tcw_pkg;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic       OP_PUT       = 1'b0;
   localparam logic       OP_READ      = 1'b1;
   localparam int         CURSOR_ROW_RESET = 2;

   typedef struct packed {
      logic       operation;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic       scrolled;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PUT,
      ST_SCROLL
   } state_type;

endpackage

### rtl/core/tcw_ram.sv
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/text_console_writer_core.sv
// Text console writer: a ROWS x COLS character screen in one RAM plus a cursor.
// A word is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with rsp_valid, and it must be captured then since
// the block has no way of holding it. A read or a put that does not scroll
// goes through ST_READ or ST_PUT and then back to ST_IDLE: the RAM has one
// write and one registered read port, so a put writes its cell in ST_PUT and a
// read takes the registered RAM data in ST_READ. A put that scrolls goes
// through ST_PUT and then ST_SCROLL: the screen is held as a rotating ring of
// rows, so a scroll only moves the top-row pointer and then sweeps the freed
// row one cell a cycle, writing the new character into its first cell. After
// reset busy stays high while the whole screen is zeroed one cell a cycle.
module text_console_writer_core #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   output tcw_pkg::rsp_type rsp_data
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS + 1);   // cursor row, may equal ROWS
   localparam int PRW   = $clog2(ROWS);       // physical row index
   localparam int SW    = RW + 1;
   localparam int CW    = $clog2(COLS + 1);   // cursor column, may equal COLS
   localparam int CIW   = $clog2(COLS);       // column index

   tcw_pkg::state_type state_ff, state_in;
   tcw_pkg::req_type   req_ff, req_in;
   tcw_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [PRW-1:0]     base_ff, base_in;
   logic [PRW-1:0]     scroll_row_ff, scroll_row_in;
   logic [CIW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]      init_cnt_ff, init_cnt_in;
   logic               in_range_ff, in_range_in;

   logic               accept;
   logic               rd_in_range;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [7:0]         rd_data;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [7:0]         mem_wd;

   logic               is_newline;
   logic               col_full;
   logic [RW-1:0]      row_step;
   logic [RW-1:0]      wrap_row;
   logic [CW-1:0]      wrap_col;
   logic               need_scroll;
   logic [PRW-1:0]     next_base;

   // ring position of a screen row given the current top row
   function automatic logic [PRW-1:0] phys_row(input logic [PRW-1:0] base,
                                               input logic [RW-1:0]  lrow);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(lrow);
      if (sum >= SW'(ROWS)) begin
         sum = sum - SW'(ROWS);
      end
      return PRW'(sum);
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [PRW-1:0] prow,
                                               input logic [CIW-1:0] col);
      return AW'(AW'(prow) * AW'(COLS) + AW'(col));
   endfunction

   assign busy   = (state_ff != tcw_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign rd_in_range = (8'(req_data.read_row) < 8'(ROWS)) &&
                        (8'(req_data.read_col) < 8'(COLS));
   assign rd_en   = accept && (req_data.operation == tcw_pkg::OP_READ);
   assign rd_addr = rd_in_range ?
                    cell_addr(phys_row(base_ff, RW'(req_data.read_row)),
                              CIW'(req_data.read_col)) : '0;

   always_comb begin
      is_newline  = (req_ff.char_code == tcw_pkg::NEWLINE_CODE);
      col_full    = (col_ff >= CW'(COLS));
      row_step    = (row_ff < RW'(ROWS)) ? RW'(row_ff + 1'b1) : row_ff;
      wrap_row    = col_full ? row_step : row_ff;
      wrap_col    = col_full ? '0 : col_ff;
      need_scroll = (wrap_row >= RW'(ROWS));
      next_base   = (base_ff == PRW'(ROWS - 1)) ? '0 : PRW'(base_ff + 1'b1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            if (init_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_data.operation == tcw_pkg::OP_READ) ?
                          tcw_pkg::ST_READ : tcw_pkg::ST_PUT;
            end
         end
         tcw_pkg::ST_READ: begin
            state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_PUT: begin
            if (!is_newline && need_scroll) begin
               state_in = tcw_pkg::ST_SCROLL;
            end else begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            if (clr_cnt_ff == CIW'(COLS - 1)) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in        = req_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      scroll_row_in = scroll_row_ff;
      clr_cnt_in    = clr_cnt_ff;
      init_cnt_in   = init_cnt_ff;
      in_range_in   = in_range_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = init_cnt_ff;
            init_cnt_in = AW'(init_cnt_ff + 1'b1);
         end
         tcw_pkg::ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               in_range_in = rd_in_range;
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.cell_char  = in_range_ff ? rd_data : 8'd0;
            rsp_data_in.cursor_row = 5'(row_ff);
            rsp_data_in.cursor_col = 7'(col_ff);
            rsp_data_in.scrolled   = 1'b0;
         end
         tcw_pkg::ST_PUT: begin
            if (is_newline) begin
               row_in                 = row_step;
               col_in                 = '0;
               rsp_valid_in           = 1'b1;
               rsp_data_in.cell_char  = 8'd0;
               rsp_data_in.cursor_row = 5'(row_step);
               rsp_data_in.cursor_col = 7'd0;
               rsp_data_in.scrolled   = 1'b0;
            end else if (need_scroll) begin
               // old top row becomes the new bottom row
               base_in       = next_base;
               scroll_row_in = base_ff;
               clr_cnt_in    = '0;
            end else begin
               mem_we                 = 1'b1;
               mem_wa                 = cell_addr(phys_row(base_ff, wrap_row),
                                                  CIW'(wrap_col));
               mem_wd                 = req_ff.char_code;
               row_in                 = wrap_row;
               col_in                 = CW'(wrap_col + 1'b1);
               rsp_valid_in           = 1'b1;
               rsp_data_in.cell_char  = 8'd0;
               rsp_data_in.cursor_row = 5'(wrap_row);
               rsp_data_in.cursor_col = 7'(CW'(wrap_col + 1'b1));
               rsp_data_in.scrolled   = 1'b0;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            // sweep the freed row, character goes into its first cell
            mem_we     = 1'b1;
            mem_wa     = cell_addr(scroll_row_ff, clr_cnt_ff);
            mem_wd     = (clr_cnt_ff == '0) ? req_ff.char_code : 8'd0;
            clr_cnt_in = CIW'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff == CIW'(COLS - 1)) begin
               row_in                 = RW'(ROWS - 1);
               col_in                 = CW'(1);
               rsp_valid_in           = 1'b1;
               rsp_data_in.cell_char  = 8'd0;
               rsp_data_in.cursor_row = 5'(ROWS - 1);
               rsp_data_in.cursor_col = 7'd1;
               rsp_data_in.scrolled   = 1'b1;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         row_ff       <= RW'(tcw_pkg::CURSOR_ROW_RESET);
         col_ff       <= '0;
         base_ff      <= '0;
         init_cnt_ff  <= '0;
         clr_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         init_cnt_ff  <= init_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_data_ff   <= rsp_data_in;
      scroll_row_ff <= scroll_row_in;
      in_range_ff   <= in_range_in;
   end

   tcw_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/tcw_checker.sv
module tcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tcw_pkg::req_type req_data,
   input logic             rsp_valid,
   input tcw_pkg::rsp_type rsp_data
);

   // a result word never directly follows another
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("no busy after an accepted word");

   // a read raises rsp_valid, registered out of the ST_READ state entered on accept
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.operation == tcw_pkg::OP_READ) |=> ##1 rsp_valid)
      else $error("read result missing");

   // a scrolled put always leaves the cursor just after the first cell
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.scrolled) |-> (rsp_data.cursor_col == 7'd1 && !busy))
      else $error("scroll result with wrong cursor");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/text_console_writer_core_tb.sv
`timescale 1ns / 100ps

module text_console_writer_core_tb;

   localparam int ROWS           = 25;
   localparam int COLS           = 80;
   localparam int RANDOM_WORDS   = 700;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int TAIL_CYCLES    = COLS + 20;

   class console_scoreboard;
      logic [7:0]       screen [ROWS][COLS];
      int unsigned      row_pos;
      int unsigned      col_pos;
      tcw_pkg::rsp_type pending_q[$];
      int               failures;
      int               results_checked;
      int               puts;
      int               reads;
      int               scrolls;

      function void clear_console();
         foreach (screen[r, c]) screen[r][c] = 8'd0;
         row_pos = tcw_pkg::CURSOR_ROW_RESET;
         col_pos = 0;
      endfunction

      function void line_feed();
         if (row_pos < ROWS) row_pos++;
         col_pos = 0;
      endfunction

      function void note_request(tcw_pkg::req_type w);
         tcw_pkg::rsp_type e;
         e = '0;
         if (w.operation == tcw_pkg::OP_READ) begin
            reads++;
            if (w.read_row < ROWS && w.read_col < COLS)
               e.cell_char = screen[w.read_row][w.read_col];
         end else if (w.char_code == tcw_pkg::NEWLINE_CODE) begin
            puts++;
            line_feed();
         end else begin
            puts++;
            if (col_pos >= COLS) line_feed();
            if (row_pos >= ROWS) begin
               for (int r = 0; r < ROWS - 1; r++) screen[r] = screen[r + 1];
               for (int c = 0; c < COLS; c++) screen[ROWS - 1][c] = 8'd0;
               row_pos   = ROWS - 1;
               col_pos   = 0;
               e.scrolled = 1'b1;
               scrolls++;
            end
            screen[row_pos][col_pos] = w.char_code;
            col_pos++;
         end
         e.cursor_row = 5'(row_pos);
         e.cursor_col = 7'(col_pos);
         pending_q.push_back(e);
      endfunction

      function void check_result(tcw_pkg::rsp_type got);
         tcw_pkg::rsp_type e;
         if (pending_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected result cell=%0d row=%0d col=%0d scrolled=%0d",
                        $realtime, got.cell_char, got.cursor_row, got.cursor_col,
                        got.scrolled);
            return;
         end
         e = pending_q.pop_front();
         results_checked++;
         if (got.cell_char !== e.cell_char || got.cursor_row !== e.cursor_row ||
             got.cursor_col !== e.cursor_col || got.scrolled !== e.scrolled) begin
            failures++;
            if (failures <= 10)
               $display("%0t: mismatch exp cell=%0d row=%0d col=%0d scrolled=%0d, %s%0d %0d %0d %0d",
                        $realtime, e.cell_char, e.cursor_row, e.cursor_col, e.scrolled,
                        "got ", got.cell_char, got.cursor_row, got.cursor_col,
                        got.scrolled);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   tcw_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   tcw_pkg::rsp_type rsp_data;

   console_scoreboard sb;
   int   words_sent  = 0;
   int   idle_cycles = 0;
   bit   no_gaps     = 0;

   text_console_writer_core #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic tcw_pkg::req_type put_word(logic [7:0] ch);
      tcw_pkg::req_type w;
      w           = tcw_pkg::req_type'($urandom);
      w.operation = tcw_pkg::OP_PUT;
      w.char_code = ch;
      return w;
   endfunction

   function automatic tcw_pkg::req_type read_word(logic [4:0] row, logic [6:0] col);
      tcw_pkg::req_type w;
      w           = tcw_pkg::req_type'($urandom);
      w.operation = tcw_pkg::OP_READ;
      w.read_row  = row;
      w.read_col  = col;
      return w;
   endfunction

   // called at a rising edge; returns at the edge that took the word
   task automatic send_word(tcw_pkg::req_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      sb.note_request(w);
      words_sent++;
   endtask

   task automatic send_text(int len, bit any_byte);
      logic [7:0] ch;
      for (int i = 0; i < len; i++) begin
         if (any_byte) ch = 8'($urandom_range(0, 255));
         else ch = 8'($urandom_range(32, 126));
         send_word(put_word(ch));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results pending", $realtime,
                     sb.pending_q.size());
            $display("text_console_writer_core_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      sb = new;
      sb.clear_console();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // freshly cleared screen, ignored fields and out-of-range reads
      send_word(read_word(5'd0, 7'd0));
      send_word('1);
      send_word(read_word(5'd25, 7'd0));
      send_word(read_word(5'd0, 7'd80));
      send_word(read_word(5'd24, 7'd79));
      send_word(put_word(8'h41));
      send_word(put_word(8'h00));
      send_word(put_word(8'hFF));
      send_word(put_word(8'h7F));
      send_word(put_word(8'h01));
      send_word(read_word(5'd2, 7'd0));
      send_word(read_word(5'd2, 7'd2));
      send_word(read_word(5'd2, 7'd3));
      send_word(put_word(tcw_pkg::NEWLINE_CODE));
      send_word(put_word(tcw_pkg::NEWLINE_CODE));
      send_word(put_word(8'h80));
      send_word(read_word(5'd4, 7'd0));
      send_word({tcw_pkg::OP_PUT, 8'hFF, 5'h1F, 7'h7F});

      while (words_sent < 18 + RANDOM_WORDS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         kind    = $urandom_range(0, 99);
         if (kind < 35) begin
            send_text($urandom_range(1, 90), $urandom_range(0, 4) == 0);
         end else if (kind < 55) begin
            // long runs pin the cursor below the last row
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(20, 30))
                  send_word(put_word(tcw_pkg::NEWLINE_CODE));
            end else begin
               repeat ($urandom_range(1, 4)) send_word(put_word(tcw_pkg::NEWLINE_CODE));
            end
         end else if (kind < 80) begin
            repeat ($urandom_range(1, 6))
               send_word(read_word(5'($urandom_range(0, ROWS - 1)),
                                   7'($urandom_range(0, COLS - 1))));
         end else if (kind < 90) begin
            repeat ($urandom_range(1, 4)) send_word(tcw_pkg::req_type'($urandom));
         end else begin
            // exactly one full row, then newline or a byte that wraps
            send_word(put_word(tcw_pkg::NEWLINE_CODE));
            send_text(COLS, 0);
            if ($urandom_range(0, 1)) send_word(put_word(tcw_pkg::NEWLINE_CODE));
            else send_word(put_word(8'($urandom_range(32, 126))));
         end
      end
      start <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("words sent %0d: %0d puts (%0d scrolls), %0d reads", words_sent,
               sb.puts, sb.scrolls, sb.reads);
      $display("results checked %0d, failures %0d", sb.results_checked, sb.failures);
      if (sb.failures == 0) begin
         $display("text_console_writer_core_tb OK");
      end else begin
         $display("text_console_writer_core_tb NOT OK");
      end
      $finish;
   end

endmodule
